// File: sv/s256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types and constants for the SHA-256 / SHA-224 hash core.
// ----------------------------------------------------------------------------
package s256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int ROUND_COUNT = 64;
  localparam int WORD_W      = 32;
  localparam int DIGEST_WORDS = 8;
  localparam int LEN_W       = 64;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [$clog2(DIGEST_WORDS)-1:0] widx_t;

  localparam word_t ROUND_K [ROUND_COUNT] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_256 [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t IV_224 [DIGEST_WORDS] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

endpackage

`default_nettype wire

// File: sv/s256_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256 channel interfaces
// Valid/ready channels for message bytes, digest words and the mode register.
// ----------------------------------------------------------------------------
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface s256_cfg_if;
  logic valid;
  logic ready;
  logic digest_mode;

  modport source (output valid, digest_mode, input ready);
  modport sink   (input valid, digest_mode, output ready);
endinterface

`default_nettype wire

// File: sv/sha256_224_hash_core_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_224_hash_core_unit
// Byte-fed SHA-256 / SHA-224 core with padding and word-serial digest output.
// ----------------------------------------------------------------------------
// A message byte is taken while the core is idle. The byte that completes a
// 64-byte block starts a compression (a load step, 64 rounds through the
// single round unit at one round per cycle, a feed-forward add), during
// which in_item.ready is low. An item with end_of_message then costs a step
// for the 0x80 marker, a step per zero byte up to the length field (at most
// 63), a step for the length field, one or two compressions, and then the
// digest words, each sent when out_item takes it (8 words in SHA-256 mode,
// 7 in SHA-224 mode). An item with neither a byte nor end_of_message is
// taken and dropped. digest_mode picks the initial values when a message
// starts and the word count when it ends.
module sha256_224_hash_core_unit (
  input  wire          clk,
  input  wire          rst,
  s256_in_if.sink      in_item,
  s256_out_if.source   out_item,
  s256_cfg_if.sink     cfg
);
  import s256_pkg::*;

  localparam int CNT_W   = $clog2(BLOCK_BYTES);
  localparam int RND_W   = $clog2(ROUND_COUNT);
  localparam int BLK_W   = 8 * BLOCK_BYTES;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_LEN  = CNT_W'(BLOCK_BYTES - LEN_W / 8);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_ZERO, S_INIT, S_ROUND, S_ADD, S_EMIT
  } state_t;

  // where to go once a compression is done
  typedef enum logic [1:0] {
    R_BYTE, R_PAD, R_FINAL
  } ret_t;

  state_t           state;
  ret_t             ret;
  logic             mode;
  logic             msg_open;
  logic             pend_last;
  logic [CNT_W-1:0] cnt;
  logic [RND_W-1:0] rnd;
  logic [LEN_W-1:0] bit_len;
  logic [BLK_W-1:0] win;       // block bytes, then the message schedule
  word_t            h  [DIGEST_WORDS];
  word_t            wv [DIGEST_WORDS];
  logic             out_valid;
  word_t            out_word;
  widx_t            out_idx;
  logic             out_last;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  word_t w_cur, w_new, t1, t2, k_cur;
  widx_t last_idx, idx_next;
  logic  in_acc, out_acc;

  assign w_cur = win[BLK_W-1 -: WORD_W];
  assign k_cur = ROUND_K[rnd];

  always_comb begin
    word_t s0, s1, w1, w14;
    w1  = win[BLK_W-1-WORD_W -: WORD_W];
    w14 = win[BLK_W-1-14*WORD_W -: WORD_W];
    s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = s1 + win[BLK_W-1-9*WORD_W -: WORD_W] + s0 + w_cur;
  end

  always_comb begin
    t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + k_cur + w_cur;
    t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign last_idx = mode ? widx_t'(DIGEST_WORDS - 2) : widx_t'(DIGEST_WORDS - 1);
  assign idx_next = out_idx + widx_t'(1);

  assign in_item.ready        = (state == S_IDLE);
  assign in_acc               = in_item.valid && in_item.ready;
  assign out_acc              = out_item.valid && out_item.ready;
  assign out_item.valid       = out_valid;
  assign out_item.digest_word = out_word;
  assign out_item.word_index  = out_idx;
  assign out_item.last_word   = out_last;
  assign cfg.ready            = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= R_BYTE;
      mode      <= 1'b0;
      msg_open  <= 1'b0;
      pend_last <= 1'b0;
      cnt       <= '0;
      rnd       <= '0;
      bit_len   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mode <= cfg.digest_mode;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!msg_open) begin
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                h[i] <= mode ? IV_224[i] : IV_256[i];
              end
            end
            pend_last <= in_item.end_of_message;
            if (in_item.byte_valid) begin
              msg_open <= 1'b1;
              win      <= {win[BLK_W-9:0], in_item.data_byte};
              cnt      <= cnt + CNT_W'(1);
              bit_len  <= bit_len + LEN_W'(8);
              if (cnt == CNT_FULL) begin
                ret   <= R_BYTE;
                state <= S_INIT;
              end else if (in_item.end_of_message) begin
                state <= S_MARK;
              end
            end else if (in_item.end_of_message) begin
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          win <= {win[BLK_W-9:0], PAD_MARK};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_FULL) begin
            ret   <= R_PAD;
            state <= S_INIT;
          end else begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (cnt == CNT_LEN) begin
            // length field closes the final block
            win   <= {win[BLK_W-LEN_W-1:0], bit_len};
            ret   <= R_FINAL;
            state <= S_INIT;
          end else begin
            win <= {win[BLK_W-9:0], 8'h00};
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_FULL) begin
              ret   <= R_PAD;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            wv[i] <= h[i];
          end
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          win   <= {win[BLK_W-WORD_W-1:0], w_new};
          rnd   <= rnd + RND_W'(1);
          if (rnd == RND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            h[i] <= h[i] + wv[i];
          end
          cnt <= '0;
          unique case (ret)
            R_BYTE:  state <= pend_last ? S_MARK : S_IDLE;
            R_PAD:   state <= S_ZERO;
            R_FINAL: begin
              out_word  <= h[0] + wv[0];
              out_idx   <= '0;
              out_last  <= 1'b0;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (out_acc) begin
            if (out_last) begin
              out_valid <= 1'b0;
              msg_open  <= 1'b0;
              bit_len   <= '0;
              cnt       <= '0;
              state     <= S_IDLE;
            end else begin
              out_idx  <= idx_next;
              out_word <= h[idx_next];
              out_last <= (idx_next == last_idx);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> !in_item.ready)
    else $error("digest output while input is open");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && out_item.ready && out_item.last_word) |=> in_item.ready)
    else $error("core not idle after final digest word");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && out_item.last_word) |->
      ((!mode && out_item.word_index == 3'd7) || (mode && out_item.word_index == 3'd6)))
    else $error("final digest word at wrong index");

  a_rounds_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == RND_LAST) |=> (state == S_ADD))
    else $error("compression did not end after the last round");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: SHA-256 / SHA-224 hash core testbench
// Feeds message bytes through the item channel, predicts each digest with a
// software hash model and checks every digest word as it leaves the core.
// ----------------------------------------------------------------------------
module tb;

  localparam bit MODE_SHA256 = 1'b0;
  localparam bit MODE_SHA224 = 1'b1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int QUIET_CYCLES = 150;   // covers a full compression plus margin
  localparam int RANDOM_ITEMS = 160;

  typedef logic [31:0] hword_t;

  localparam hword_t RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam hword_t H0_256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam hword_t H0_224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  typedef struct {
    hword_t     word;
    logic [2:0] pos;
    logic       last;
  } digest_word_t;

  class digest_scoreboard;
    bit           sha224;
    hword_t       chain [8];
    logic [7:0]   blk_bytes [64];
    int unsigned  fill;
    logic [63:0]  bit_len;
    bit           msg_open;
    digest_word_t expected_q [$];
    int           errors;
    int           words_checked;
    int           digests;

    function new();
      sha224 = MODE_SHA256;
      errors = 0;
      words_checked = 0;
      digests = 0;
      load_iv();
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
      fill = 0;
      bit_len = '0;
      msg_open = 1'b0;
    endfunction

    function void load_iv();
      foreach (chain[i]) chain[i] = sha224 ? H0_224[i] : H0_256[i];
    endfunction

    function void set_mode(bit m);
      sha224 = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function hword_t rotr(hword_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      hword_t w [16];
      hword_t v [8];
      hword_t wt, a, b, s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      v = chain;
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          wt = w[i];
        end else begin
          a  = w[(i - 15) & 15];
          b  = w[(i - 2) & 15];
          s0 = rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3);
          s1 = rotr(b, 17) ^ rotr(b, 19) ^ (b >> 10);
          wt = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
          w[i & 15] = wt;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + wt;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
      fill = 0;
    endfunction

    // one accepted input item
    function void note_item(logic [7:0] d, logic bv, logic eom);
      digest_word_t e;
      int n;
      // initial values follow the mode until the first byte of a message
      if (!msg_open) load_iv();
      if (bv) begin
        msg_open = 1'b1;
        blk_bytes[fill & 63] = d;
        fill++;
        bit_len = bit_len + 64'd8;
        if (fill >= 64) compress();
      end
      if (!eom) return;
      blk_bytes[fill & 63] = 8'h80;
      fill++;
      if (fill > 56) compress();
      for (int i = 0; i < 8; i++) blk_bytes[63 - i] = bit_len[8*i +: 8];
      compress();
      n = sha224 ? 7 : 8;
      for (int i = 0; i < n; i++) begin
        e.word = chain[i];
        e.pos  = i[2:0];
        e.last = (i == n - 1);
        expected_q.push_back(e);
      end
      digests++;
      bit_len = '0;
      fill = 0;
      msg_open = 1'b0;
      load_iv();
    endfunction

    function void check_word(hword_t word, logic [2:0] pos, logic last);
      digest_word_t e;
      words_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t ERROR unexpected word: expected none, actual %h idx %0d last %0b",
                 $time, word, pos, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (word !== e.word) begin
        $display("%0t ERROR digest_word: expected %h, actual %h", $time, e.word, word);
        errors++;
      end
      if (pos !== e.pos) begin
        $display("%0t ERROR word_index: expected %0d, actual %0d", $time, e.pos, pos);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t ERROR last_word: expected %0b, actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  s256_in_if  in_ch ();
  s256_out_if out_ch ();
  s256_cfg_if cfg_ch ();

  sha256_224_hash_core_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg      (cfg_ch)
  );

  digest_scoreboard sb;
  int  cycles = 0;
  int  hold_req = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;
  int  mode_writes = 0;
  int  items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still due", cycles, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // digest receiver: per-word stall, plus the long hold when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      out_ch.ready = (stall_left == 0) && !rst;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [7:0] d, logic bv, logic eom);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.data_byte      = d;
    in_ch.byte_valid     = bv;
    in_ch.end_of_message = eom;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(d, bv, eom);
    @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_ch.valid       = 1'b1;
    cfg_ch.digest_mode = m;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_mode(m);
    mode_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // random-content message, optionally with a mode toggle halfway through
  task automatic send_message(int len, bit mid_write);
    bit sep_term;
    sep_term = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (mid_write && k == len / 2) write_mode(sb.sha224 ? MODE_SHA256 : MODE_SHA224);
      send_item(8'($urandom_range(0, 255)), 1'b1, !sep_term && (k == len - 1));
      items_sent++;
    end
    if (sep_term) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin
    int mcount;
    int len;
    sb = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.byte_valid = 1'b0;
    in_ch.end_of_message = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.digest_mode = MODE_SHA256;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty message, "abc", idle item, extreme bytes, both modes
    write_mode(MODE_SHA256);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    write_mode(MODE_SHA224);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // mode change inside a message: IVs kept, word count follows the new mode
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    write_mode(MODE_SHA256);
    send_item(8'h56, 1'b1, 1'b1);
    send_item(8'ha5, 1'b1, 1'b0);
    write_mode(MODE_SHA224);
    send_item(8'hc3, 1'b0, 1'b1);

    // random: padding boundaries first, then mostly short messages
    mcount = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (mcount == 0)      len = 55;
      else if (mcount == 1) len = 56;
      else if (mcount == 2) len = 64;
      else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          default: len = 64;
        endcase
      end else begin
        len = $urandom_range(0, 12);
      end
      no_idle = (mcount >= 4 && mcount <= 6) || (mcount >= 12 && mcount <= 14);
      // long receiver hold while bytes keep coming, so the core backs up
      if (mcount == 4) hold_req = 400;
      if (mcount > 2 && mcount != 4 && $urandom_range(0, 3) == 0)
        write_mode(bit'($urandom_range(0, 1)));
      send_message(len, len > 1 && $urandom_range(0, 9) == 0);
      mcount++;
    end
    in_ch.valid = 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("Ran %0d digests (%0d words checked) over %0d random messages,",
             sb.digests, sb.words_checked, mcount);
    $display("with %0d mode writes, mid-message mode changes and a long output hold.",
             mode_writes);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
